>>> rtl/cltr_pkg.sv
// Shared types, constants and spelling tables for the command line token recognizer.
// No dependencies; every other file imports this package.
package cltr_pkg;

	localparam int unsigned WORD_COUNT = 16;
	localparam int unsigned VERB_COUNT = 11;
	localparam int unsigned REPLY_COUNT = WORD_COUNT - VERB_COUNT;
	localparam int unsigned TEXT_MAX = 12;
	localparam int unsigned ARG_W = 16;
	localparam int unsigned TLEN_OUT_W = 5;
	localparam int unsigned CODE_W = 4;
	// Width used when comparing token lengths against spelling lengths.
	localparam int unsigned CMP_W = 7;

	typedef logic [7:0] byte_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [ARG_W-1:0] arg_len_t;
	typedef logic [WORD_COUNT-1:0] cand_mask_t;
	typedef logic [8*TEXT_MAX-1:0] word_text_t;
	typedef logic [3:0] word_len_t;

	typedef enum logic {
		SET_REQUEST = 1'b0,
		SET_REPLY   = 1'b1
	} token_set_t;

	localparam code_t CODE_UNKNOWN = '0;
	localparam byte_t CHAR_SPACE = 8'h20;
	localparam arg_len_t ARG_MAX = '1;

	// Verbs first (status..revoke), then reply words (ok..malformed).
	// Strings are right-justified: the first character sits highest.
	localparam word_text_t WORD_TEXT [WORD_COUNT] = '{
		"status", "log", "get", "set", "list", "add", "remove", "fetch", "put",
		"grant", "revoke",
		"ok", "denied", "unsupported", "error", "malformed"
	};

	localparam word_len_t WORD_LEN [WORD_COUNT] = '{
		4'd6, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd3, 4'd5, 4'd6,
		4'd2, 4'd6, 4'd11, 4'd5, 4'd9
	};

	localparam cand_mask_t WORD_MUTATES = 16'b0000_0111_0110_1000;

	// True when spelling k has byte b at position pos.
	function automatic logic char_hit(input int unsigned k, input logic [CMP_W-1:0] pos,
			input byte_t b);
		logic [6:0] sh;
		logic       hit;
		hit = 1'b0;
		sh  = '0;
		if (pos < CMP_W'(WORD_LEN[k])) begin
			sh  = 7'(8 * (int'(WORD_LEN[k]) - 1 - int'(pos)));
			hit = (WORD_TEXT[k][sh +: 8] == b);
		end
		return hit;
	endfunction

endpackage

>>> rtl/cltr_if.sv
// Request channel interfaces for the command line token recognizer:
// input bytes, results and the configuration write. Depends on cltr_pkg.
interface cltr_in_if import cltr_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cltr_out_if import cltr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  well_formed;
	code_t                 token_code;
	logic                  changes_state;
	logic [TLEN_OUT_W-1:0] token_length;
	logic                  has_argument;
	arg_len_t              argument_length;

	modport source (output valid, output well_formed, output token_code,
		output changes_state, output token_length, output has_argument,
		output argument_length, input ready);
	modport sink (input valid, input well_formed, input token_code,
		input changes_state, input token_length, input has_argument,
		input argument_length, output ready);
endinterface

interface cltr_cfg_if import cltr_pkg::*; ();
	logic valid;
	logic ready;
	logic token_set;

	modport source (output valid, output token_set, input ready);
	modport sink (input valid, input token_set, output ready);
endinterface

>>> rtl/command_line_token_recognizer.sv
// Top level of the command line token recognizer: byte input register, per-line
// match state and result register. Depends on cltr_pkg and the cltr_*_if interfaces.
//
// Feed one protocol line as a stream of byte requests on "bytes", flagging the
// final byte with last_byte. The block splits the line at its first space, matches
// the leading token against the request verbs (token_set = 0) or the reply words
// (token_set = 1), and delivers exactly one result request per line, taken from the
// last byte. Each byte is captured in an input register, and from there a short
// update of a 16-bit candidate mask, two counters and a space flag runs, with the
// final byte also loading the result register. A byte is accepted every cycle;
// only a last byte waiting behind an untaken result holds off the input, and the
// result register lets a new line stream in while a result waits. A last byte
// passes through the input register and then the result register. Write token_set
// only while no line is in flight; the cfg port is always ready.
module command_line_token_recognizer import cltr_pkg::*; #(
	parameter int unsigned TOKEN_MAX = 16
) (
	input logic        clk,
	input logic        arst_n,
	cltr_in_if.sink    bytes,
	cltr_out_if.source result,
	cltr_cfg_if.sink   cfg
);

	// Token length counter saturates at TOKEN_MAX + 1.
	localparam int unsigned TLEN_W = $clog2(TOKEN_MAX + 2);
	localparam logic [TLEN_W-1:0] TLEN_SAT = TLEN_W'(TOKEN_MAX + 1);
	localparam logic [TLEN_W-1:0] TLEN_LIMIT = TLEN_W'(TOKEN_MAX);

	// Configuration register.
	token_set_t token_set_q;

	// Input register stage.
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;
	logic  adv_s1;

	// Per-line state.
	logic              space_q;
	logic [TLEN_W-1:0] tlen_q;
	cand_mask_t        mask_q;
	arg_len_t          rest_q;

	// Next-state values for the byte in stage 1.
	logic              space_d;
	logic [TLEN_W-1:0] tlen_d;
	cand_mask_t        mask_d;
	arg_len_t          rest_d;

	// Result decode.
	logic  ok;
	code_t code_d;
	logic  changes_d;

	// Result register.
	logic                  out_valid_q;
	logic                  well_formed_q;
	code_t                 token_code_q;
	logic                  changes_q;
	logic [TLEN_OUT_W-1:0] token_length_q;
	logic                  has_arg_q;
	arg_len_t              arg_len_q;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_set_q <= SET_REQUEST;
		end else if (cfg.valid) begin
			token_set_q <= token_set_t'(cfg.token_set);
		end
	end

	// Advance stage 1 unless it holds a last byte and the result register is stuck.
	assign adv_s1 = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign bytes.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	// Per-byte update: count the rest after the space, take the first space,
	// otherwise knock out every spelling that disagrees at this position.
	always_comb begin
		space_d = space_q;
		tlen_d  = tlen_q;
		mask_d  = mask_q;
		rest_d  = rest_q;
		if (space_q) begin
			if (rest_q != ARG_MAX) begin
				rest_d = rest_q + 1'b1;
			end
		end else if (byte_s1 == CHAR_SPACE) begin
			space_d = 1'b1;
		end else begin
			for (int unsigned k = 0; k < WORD_COUNT; k++) begin
				if (!char_hit(k, CMP_W'(tlen_q), byte_s1)) begin
					mask_d[k] = 1'b0;
				end
			end
			if (tlen_q != TLEN_SAT) begin
				tlen_d = tlen_q + 1'b1;
			end
		end
	end

	// Line-end decode: the lowest surviving spelling of exactly the token length wins.
	assign ok = (tlen_d != '0) && (tlen_d <= TLEN_LIMIT);

	always_comb begin
		code_d    = CODE_UNKNOWN;
		changes_d = 1'b0;
		if (token_set_q == SET_REQUEST) begin
			for (int k = int'(VERB_COUNT) - 1; k >= 0; k--) begin
				if (mask_d[k] && (CMP_W'(tlen_d) == CMP_W'(WORD_LEN[k]))) begin
					code_d    = CODE_W'(k + 1);
					changes_d = WORD_MUTATES[k];
				end
			end
		end else begin
			for (int k = int'(WORD_COUNT) - 1; k >= int'(VERB_COUNT); k--) begin
				if (mask_d[k] && (CMP_W'(tlen_d) == CMP_W'(WORD_LEN[k]))) begin
					code_d = CODE_W'(k - int'(VERB_COUNT) + 1);
				end
			end
		end
	end

	// Advance line state; clear it after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q <= 1'b0;
			tlen_q  <= '0;
			mask_q  <= '1;
			rest_q  <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				space_q <= 1'b0;
				tlen_q  <= '0;
				mask_q  <= '1;
				rest_q  <= '0;
			end else begin
				space_q <= space_d;
				tlen_q  <= tlen_d;
				mask_q  <= mask_d;
				rest_q  <= rest_d;
			end
		end
	end

	// Result register: drop valid when taken, load on a last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			well_formed_q  <= ok;
			token_code_q   <= ok ? code_d : CODE_UNKNOWN;
			changes_q      <= ok && changes_d;
			token_length_q <= ok ? TLEN_OUT_W'(tlen_d) : '0;
			has_arg_q      <= ok && space_d;
			arg_len_q      <= (ok && space_d) ? rest_d : '0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.well_formed     = well_formed_q;
	assign result.token_code      = token_code_q;
	assign result.changes_state   = changes_q;
	assign result.token_length    = token_length_q;
	assign result.has_argument    = has_arg_q;
	assign result.argument_length = arg_len_q;

	// A last byte finishing in stage 1 always shows up as a result next cycle.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("last byte produced no result");

	// A stuck result must hold off a waiting last byte and the input.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !result.ready |-> !bytes.ready)
		else $error("input accepted while last byte blocked");

	// Malformed lines report all-zero fields.
	a_malformed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !well_formed_q |-> token_code_q == CODE_UNKNOWN && !changes_q
			&& token_length_q == '0 && !has_arg_q && arg_len_q == '0)
		else $error("malformed result carries nonzero fields");

	// A state-changing result must be a recognized, well formed verb.
	a_changes_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && changes_q |-> well_formed_q && token_code_q != CODE_UNKNOWN)
		else $error("changes_state set on unknown token");

	// Rest bytes are only counted after the separating space.
	a_rest_after_space: assert property (@(posedge clk) disable iff (!arst_n)
		!space_q |-> rest_q == '0)
		else $error("rest counted before space");

endmodule

>>> sim/command_line_token_recognizer_test.sv
// Self-checking testbench for command_line_token_recognizer: drives byte lines and
// token_set writes, predicts each line's result and checks it. Depends on cltr_pkg
// and the cltr_in_if, cltr_out_if and cltr_cfg_if interfaces.
module command_line_token_recognizer_test import cltr_pkg::*; ();

	localparam int unsigned TOKEN_LIMIT = 16;
	localparam int unsigned PERIOD = 8;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned PHASE_BYTES = 160;
	localparam int unsigned REST_LIMIT = 65535;

	// One line summary as the result channel carries it.
	typedef struct packed {
		logic                  well_formed;
		code_t                 token_code;
		logic                  changes_state;
		logic [TLEN_OUT_W-1:0] token_length;
		logic                  has_argument;
		arg_len_t              argument_length;
	} line_result_t;

	// Tracks the line being streamed, predicts its summary on the last byte,
	// and checks every summary the block returns against the oldest prediction.
	class token_scoreboard;
		string spelling[16] = '{"status", "log", "get", "set", "list", "add", "remove",
			"fetch", "put", "grant", "revoke",
			"ok", "denied", "unsupported", "error", "malformed"};
		bit alters[11] = '{0, 0, 0, 1, 0, 1, 1, 0, 1, 1, 1};
		line_result_t expected_q[$];
		token_set_t mode = SET_REQUEST;
		bit space_seen;
		int unsigned token_bytes;
		bit [15:0] candidates = '1;
		int unsigned rest_bytes;
		int unsigned mismatches;

		function void clear_line();
			space_seen = 1'b0;
			token_bytes = 0;
			candidates = '1;
			rest_bytes = 0;
		endfunction

		function void note_byte(byte_t b, logic last);
			line_result_t r;
			int first;
			int stop;
			if (space_seen) begin
				if (rest_bytes < REST_LIMIT)
					rest_bytes++;
			end else if (b == CHAR_SPACE) begin
				space_seen = 1'b1;
			end else begin
				// drop every spelling that is too short or differs at this position
				for (int k = 0; k < 16; k++) begin
					if (token_bytes >= spelling[k].len() ||
							byte_t'(spelling[k][token_bytes]) != b)
						candidates[k] = 1'b0;
				end
				if (token_bytes < TOKEN_LIMIT + 1)
					token_bytes++;
			end
			if (!last)
				return;
			r = '0;
			if (token_bytes >= 1 && token_bytes <= TOKEN_LIMIT) begin
				first = (mode == SET_REPLY) ? VERB_COUNT : 0;
				stop = (mode == SET_REPLY) ? WORD_COUNT : VERB_COUNT;
				r.well_formed = 1'b1;
				r.token_code = CODE_UNKNOWN;
				for (int k = first; k < stop; k++) begin
					if (candidates[k] && spelling[k].len() == token_bytes) begin
						r.token_code = code_t'(k - first + 1);
						r.changes_state = (mode == SET_REQUEST) && alters[k];
						break;
					end
				end
				r.token_length = token_bytes[TLEN_OUT_W-1:0];
				r.has_argument = space_seen;
				r.argument_length = space_seen ? arg_len_t'(rest_bytes) : '0;
			end
			expected_q.push_back(r);
			clear_line();
		endfunction

		function string show(line_result_t r);
			return $sformatf("wf=%0b code=%0d chg=%0b tlen=%0d arg=%0b alen=%0d",
				r.well_formed, r.token_code, r.changes_state, r.token_length,
				r.has_argument, r.argument_length);
		endfunction

		function void check_result(line_result_t got);
			line_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: result with no line pending, got %s", show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cltr_in_if bytes_if ();
	cltr_out_if result_if ();
	cltr_cfg_if cfg_if ();

	command_line_token_recognizer #(
		.TOKEN_MAX(TOKEN_LIMIT)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if.sink),
		.result (result_if.source),
		.cfg    (cfg_if.sink)
	);

	token_scoreboard sb = new;

	int unsigned idle_pct;      // chance per cycle that the sender holds off
	int unsigned stall_pct;     // chance per cycle that the receiver holds off
	int unsigned hold_len;      // long receiver hold-off, counted down at negedge
	int unsigned bytes_sent;
	int unsigned quiet_cycles;

	always #(PERIOD / 2) clk = ~clk;

	// Receiver: drop ready at random, or for a whole stretch when a long
	// hold-off has been requested by the stimulus.
	always @(negedge clk) begin
		if (hold_len != 0) begin
			result_if.ready <= 1'b0;
			hold_len--;
		end else begin
			result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Sample every handshake at the rising edge: register writes, accepted bytes
	// and returned results. Also run the watchdog on cycles with no request moving.
	always @(posedge clk) begin : monitor
		line_result_t got;
		bit busy;
		busy = 1'b0;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				sb.mode = token_set_t'(cfg_if.token_set);
				busy = 1'b1;
			end
			if (bytes_if.valid && bytes_if.ready) begin
				sb.note_byte(bytes_if.data_byte, bytes_if.last_byte);
				busy = 1'b1;
			end
			if (result_if.valid && result_if.ready) begin
				got.well_formed = result_if.well_formed;
				got.token_code = result_if.token_code;
				got.changes_state = result_if.changes_state;
				got.token_length = result_if.token_length;
				got.has_argument = result_if.has_argument;
				got.argument_length = result_if.argument_length;
				sb.check_result(got);
				busy = 1'b1;
			end
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Offer one byte request at the falling edge, after a random number of idle
	// cycles, and hold it until the block takes it at a rising edge.
	task automatic send_byte(input byte_t b, input logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			bytes_if.valid <= 1'b0;
			@(negedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= b;
		bytes_if.last_byte <= last;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line(input byte_t q[$]);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(byte_t'(s[i]), i == s.len() - 1);
	endtask

	// Drop valid after the last accepted byte so nothing is taken twice.
	task automatic stop_input();
		@(negedge clk);
		bytes_if.valid <= 1'b0;
	endtask

	// Wait until every predicted summary has come back, then let the pipeline settle.
	task automatic wait_drained();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_token_set(input token_set_t v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.token_set <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Any byte value except the space, so a token never splits early.
	function automatic byte_t token_char();
		byte_t b;
		b = byte_t'($urandom_range(0, 254));
		if (b >= CHAR_SPACE)
			b++;
		return b;
	endfunction

	// Build and send one random line. Most lines carry a real verb or reply word so
	// the match logic is exercised; the rest are near misses, random or oversized
	// tokens, lines with a leading space, and plain junk.
	task automatic random_line();
		byte_t q[$];
		string w;
		int kind;
		int n;
		int pick;
		bit tail;
		kind = $urandom_range(0, 99);
		w = sb.spelling[$urandom_range(0, WORD_COUNT - 1)];
		tail = 1'b1;
		if (kind < 55) begin
			for (int i = 0; i < w.len(); i++)
				q.push_back(byte_t'(w[i]));
		end else if (kind < 65) begin
			pick = $urandom_range(0, 2);
			n = (pick == 0) ? $urandom_range(1, w.len() - 1) : w.len();
			for (int i = 0; i < n; i++)
				q.push_back(byte_t'(w[i]));
			if (pick == 1)
				q.push_back(token_char());
			else if (pick == 2)
				q[$urandom_range(0, n - 1)] = token_char();
		end else if (kind < 77) begin
			// favor lengths around the token limit
			n = $urandom_range(0, 1) ? $urandom_range(TOKEN_LIMIT - 1, TOKEN_LIMIT + 2)
				: $urandom_range(1, TOKEN_LIMIT - 2);
			repeat (n) q.push_back(token_char());
		end else if (kind < 83) begin
			repeat ($urandom_range(TOKEN_LIMIT + 1, 40)) q.push_back(token_char());
		end else if (kind < 89) begin
			q.push_back(CHAR_SPACE);
		end else if (kind < 94) begin
			q.push_back(byte_t'($urandom_range(0, 255)));
			tail = 1'b0;
		end else begin
			repeat ($urandom_range(1, 10)) q.push_back(byte_t'($urandom_range(0, 255)));
			tail = 1'b0;
		end
		if (tail) begin
			pick = $urandom_range(0, 9);
			if (pick >= 3 || q[0] == CHAR_SPACE) begin
				if (q[0] != CHAR_SPACE)
					q.push_back(CHAR_SPACE);
				n = (pick == 9) ? $urandom_range(0, 80) : $urandom_range(0, 10);
				repeat (n) q.push_back(byte_t'($urandom_range(0, 255)));
			end
		end
		send_line(q);
	endtask

	initial begin
		int unsigned phase_start;
		clk = 1'b0;
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = '0;
		bytes_if.last_byte = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.token_set = SET_REQUEST;
		result_if.ready = 1'b1;
		idle_pct = 0;
		stall_pct = 0;
		hold_len = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phases: no idling, sender idle, receiver stalling, both idling.
		// Alternate the token set so each mode sees traffic under pressure.
		for (int p = 0; p < 4; p++) begin
			idle_pct = (p == 1) ? 50 : (p == 3) ? 17 : 0;
			stall_pct = (p == 2) ? 50 : (p == 3) ? 17 : 0;
			wait_drained();
			write_token_set((p % 2 == 1) ? SET_REPLY : SET_REQUEST);
			phase_start = bytes_sent;
			if (p == 0) begin
				// byte extremes, lone space, leading space, space as last byte,
				// extra spaces in the rest, reply word in request mode, a verb
				send_byte(8'h00, 1'b1);
				send_byte(8'hFF, 1'b1);
				send_text(" ");
				send_text(" x");
				send_text("put ");
				send_text("log a  b");
				send_text("ok");
				send_text("revoke");
				// hold the receiver off for a long stretch while bytes keep coming
				stop_input();
				hold_len = 300;
			end
			while (bytes_sent - phase_start < PHASE_BYTES)
				random_line();
			stop_input();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
